// ----- sv/fmrq_pkg.sv -----
// ----------------------------------------------------------------------------
// fmrq_pkg
// shared types and constants of the framed message receive queue
// ----------------------------------------------------------------------------
`default_nettype none

package fmrq_pkg;

  // default sizes
  localparam int unsigned MAX_LEN_DEF     = 32;
  localparam int unsigned QUEUE_DEPTH_DEF = 16;

  // fixed field widths
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned CFG_IDX_W = 4;

  // marker reset values
  localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'hFA;
  localparam logic [BYTE_W-1:0] STOP_MARKER_RST  = 8'hFB;

  // item modes
  localparam logic [MODE_W-1:0] MODE_RX   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ = 2'd1;
  localparam logic [MODE_W-1:0] MODE_STOP = 2'd2;
  localparam logic [MODE_W-1:0] MODE_POP  = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_MARKER  = 4'd1;

  // last bus event
  typedef enum logic [1:0] {
    EVT_NONE = 2'd0,
    EVT_RX   = 2'd1,
    EVT_READ = 2'd2
  } evt_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COPY,
    ST_COPY_END,
    ST_POP
  } state_t;

endpackage : fmrq_pkg

`default_nettype wire

// ----- sv/framed_message_receive_queue_top.sv -----
// ----------------------------------------------------------------------------
// framed_message_receive_queue_top
// assembles received bus bytes into framed messages and queues kept ones
// ----------------------------------------------------------------------------
// results: a read request gives its result in the cycle after acceptance; a
//   pop gives its first byte from the registered store read once in ST_POP, then
//   one byte a cycle; byte receive, read request and a discarding stop leave
//   the block free for the next item, a kept stop and a pop hold it busy for
//   the whole message, set by the single read port of buffer and store
// reset: synchronous active-low rst_n clears the queue pointers and flags and
//   restores the markers; the result strobe is never held off by the receiver
`default_nettype none

module framed_message_receive_queue_top #(
  parameter int unsigned MAX_LEN     = fmrq_pkg::MAX_LEN_DEF,
  parameter int unsigned QUEUE_DEPTH = fmrq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input item channel
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [fmrq_pkg::MODE_W-1:0]   in_mode,
  input  wire logic [fmrq_pkg::BYTE_W-1:0]   in_rx_byte,
  // result channel
  output logic                               out_valid,
  output logic [fmrq_pkg::BYTE_W-1:0]        out_byte,
  output logic                               out_last,
  output logic                               out_empty_res,
  // configuration write channel
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [fmrq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [fmrq_pkg::BYTE_W-1:0]   cfg_data
);

  import fmrq_pkg::*;

  // length counts 0..MAX_LEN, byte index 0..MAX_LEN-1, slot 0..QUEUE_DEPTH-1
  localparam int unsigned LEN_W    = $clog2(MAX_LEN + 1);
  localparam int unsigned IDX_W    = $clog2(MAX_LEN);
  localparam int unsigned SLOT_W   = $clog2(QUEUE_DEPTH);
  localparam int unsigned STORE_D  = QUEUE_DEPTH * (2 ** IDX_W);

  // --------------------------------------------------------------------------
  // memories: assembly buffer, message store (one row per slot), lengths
  // --------------------------------------------------------------------------
  logic [BYTE_W-1:0] asm_mem   [MAX_LEN];
  logic [BYTE_W-1:0] store_mem [STORE_D];
  logic [LEN_W-1:0]  len_mem   [QUEUE_DEPTH];

  logic [BYTE_W-1:0] asm_q_r;
  logic [BYTE_W-1:0] store_q_r;
  logic [LEN_W-1:0]  len_q_r;

  logic              asm_we;
  logic [IDX_W-1:0]  asm_waddr;
  logic              len_we;

  // --------------------------------------------------------------------------
  // control and payload registers
  // --------------------------------------------------------------------------
  state_t            state_r, state_nxt;
  logic [LEN_W-1:0]  asm_len_r, asm_len_nxt;
  evt_t              evt_r, evt_nxt;
  logic [SLOT_W-1:0] head_r, head_nxt;
  logic [SLOT_W-1:0] tail_r, tail_nxt;
  logic              full_r, full_nxt;
  logic              ready_r, ready_nxt;
  logic [IDX_W-1:0]  cnt_r, cnt_nxt;

  // first and most recent byte of the assembly, for the frame check at stop
  logic [BYTE_W-1:0] first_r, first_nxt;
  logic [BYTE_W-1:0] lastb_r, lastb_nxt;

  logic [BYTE_W-1:0] start_marker_r;
  logic [BYTE_W-1:0] stop_marker_r;

  // copy write runs in the cycle after the assembly read
  logic              wr_pend_r, wr_pend_nxt;
  logic [IDX_W-1:0]  wr_idx_r, wr_idx_nxt;

  // result registers; out_byte comes from the store read or the status bit
  logic              out_valid_r, out_valid_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_empty_r, out_empty_nxt;
  logic              out_mem_r, out_mem_nxt;
  logic              out_stat_r, out_stat_nxt;

  logic              accept;
  logic [LEN_W-1:0]  cnt_inc;
  logic [SLOT_W-1:0] tail_inc;
  logic [SLOT_W-1:0] head_inc;
  logic              q_empty;
  logic              frame_ok;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  assign cnt_inc  = LEN_W'(cnt_r) + LEN_W'(1);
  assign tail_inc = (tail_r == SLOT_W'(QUEUE_DEPTH - 1)) ? '0 : tail_r + SLOT_W'(1);
  assign head_inc = (head_r == SLOT_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + SLOT_W'(1);
  assign q_empty  = (head_r == tail_r) && !full_r;

  // kept only after a receive, with room, non-empty and properly framed
  assign frame_ok = (evt_r == EVT_RX) && !full_r && (asm_len_r != '0) &&
                    (first_r == start_marker_r) && (lastb_r == stop_marker_r);

  assign asm_waddr = asm_len_r[IDX_W-1:0];

  // --------------------------------------------------------------------------
  // sequencer: next state and datapath controls
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    asm_len_nxt   = asm_len_r;
    evt_nxt       = evt_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    full_nxt      = full_r;
    ready_nxt     = ready_r;
    cnt_nxt       = cnt_r;
    first_nxt     = first_r;
    lastb_nxt     = lastb_r;
    wr_pend_nxt   = 1'b0;
    wr_idx_nxt    = cnt_r;
    out_valid_nxt = 1'b0;
    out_last_nxt  = 1'b0;
    out_empty_nxt = 1'b0;
    out_mem_nxt   = 1'b0;
    out_stat_nxt  = 1'b0;
    asm_we        = 1'b0;
    len_we        = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_mode)
            MODE_RX: begin
              // bytes beyond the maximum length are dropped silently
              if (asm_len_r < LEN_W'(MAX_LEN)) begin
                asm_we      = 1'b1;
                asm_len_nxt = asm_len_r + LEN_W'(1);
                evt_nxt     = EVT_RX;
                lastb_nxt   = in_rx_byte;
                if (asm_len_r == '0) begin
                  first_nxt = in_rx_byte;
                end
              end
            end
            MODE_READ: begin
              out_valid_nxt = 1'b1;
              out_last_nxt  = 1'b1;
              out_stat_nxt  = ready_r;
              evt_nxt       = EVT_READ;
            end
            MODE_STOP: begin
              if (frame_ok) begin
                len_we    = 1'b1;
                ready_nxt = 1'b1;
                cnt_nxt   = '0;
                state_nxt = ST_COPY;
              end else begin
                asm_len_nxt = '0;
              end
            end
            MODE_POP: begin
              if (q_empty) begin
                out_valid_nxt = 1'b1;
                out_last_nxt  = 1'b1;
                out_empty_nxt = 1'b1;
              end else begin
                // length of the head slot lands in len_q_r at this edge
                cnt_nxt   = '0;
                state_nxt = ST_POP;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_COPY: begin
        // assembly byte cnt_r is read now and written to the store next cycle
        wr_pend_nxt = 1'b1;
        wr_idx_nxt  = cnt_r;
        cnt_nxt     = cnt_r + IDX_W'(1);
        if (cnt_inc >= asm_len_r) begin
          state_nxt = ST_COPY_END;
        end
      end

      ST_COPY_END: begin
        // last byte is written this cycle
        asm_len_nxt = '0;
        tail_nxt    = tail_inc;
        full_nxt    = (tail_inc == head_r);
        state_nxt   = ST_IDLE;
      end

      ST_POP: begin
        out_valid_nxt = 1'b1;
        out_mem_nxt   = 1'b1;
        cnt_nxt       = cnt_r + IDX_W'(1);
        if (cnt_inc >= len_q_r) begin
          out_last_nxt = 1'b1;
          head_nxt     = head_inc;
          full_nxt     = 1'b0;
          ready_nxt    = 1'b0;
          state_nxt    = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      asm_len_r   <= '0;
      evt_r       <= EVT_NONE;
      head_r      <= '0;
      tail_r      <= '0;
      full_r      <= 1'b0;
      ready_r     <= 1'b0;
      cnt_r       <= '0;
      wr_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      asm_len_r   <= asm_len_nxt;
      evt_r       <= evt_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      full_r      <= full_nxt;
      ready_r     <= ready_nxt;
      cnt_r       <= cnt_nxt;
      wr_pend_r   <= wr_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    first_r     <= first_nxt;
    lastb_r     <= lastb_nxt;
    wr_idx_r    <= wr_idx_nxt;
    out_last_r  <= out_last_nxt;
    out_empty_r <= out_empty_nxt;
    out_mem_r   <= out_mem_nxt;
    out_stat_r  <= out_stat_nxt;
  end

  // marker registers, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_marker_r <= START_MARKER_RST;
      stop_marker_r  <= STOP_MARKER_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_START_MARKER: start_marker_r <= cfg_data;
        CFG_STOP_MARKER:  stop_marker_r  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // memory ports
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (asm_we) begin
      asm_mem[asm_waddr] <= in_rx_byte;
    end
    asm_q_r <= asm_mem[cnt_r];
  end

  always_ff @(posedge clk) begin
    if (wr_pend_r) begin
      store_mem[{tail_r, wr_idx_r}] <= asm_q_r;
    end
    store_q_r <= store_mem[{head_r, cnt_r}];
  end

  always_ff @(posedge clk) begin
    if (len_we) begin
      len_mem[tail_r] <= asm_len_r;
    end
    len_q_r <= len_mem[head_r];
  end

  // --------------------------------------------------------------------------
  // result ports
  // --------------------------------------------------------------------------
  assign out_valid     = out_valid_r;
  assign out_byte      = out_mem_r ? store_q_r : {{(BYTE_W-1){1'b0}}, out_stat_r};
  assign out_last      = out_last_r;
  assign out_empty_res = out_empty_r;

endmodule : framed_message_receive_queue_top

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the framed message receive queue
// ----------------------------------------------------------------------------
// a short table of hand-picked bus events runs first, then random frames
// (good, broken, overlong) with random reads, pops and noise under four
// marker settings; results, predicted or from the table, are checked in order
// ----------------------------------------------------------------------------

module tb_top;
  import fmrq_pkg::*;

  localparam int unsigned FRAME_MAX      = MAX_LEN_DEF;
  localparam int unsigned RING_DEPTH     = QUEUE_DEPTH_DEF;
  // a kept stop copies up to FRAME_MAX bytes with no result to show for it
  localparam int          SETTLE_CYCLES  = FRAME_MAX + 8;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          MAX_GAP        = 40;

  // index past the last register, must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 4'd15;

  // one result item as seen on the result ports
  typedef struct packed {
    logic [BYTE_W-1:0] byte_val;
    logic              fin;
    logic              empty_flag;
  } res_t;

  // one row of the directed table; typed rows carry their own expectation
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [BYTE_W-1:0] data;
    logic              typed;
    res_t              want;
  } dir_row_t;

  localparam res_t NO_RES      = '0;
  localparam res_t RES_EMPTY   = '{8'h00, 1'b1, 1'b1};
  localparam res_t RES_FLAG_LO = '{8'h00, 1'b1, 1'b0};
  localparam res_t RES_FLAG_HI = '{8'h01, 1'b1, 1'b0};
  localparam int   N_DIRECTED  = 23;

  // clock and dut ports, the inputs driven to known values from time zero
  logic                 clk;
  logic                 rst_n      = 1'b0;
  logic                 start      = 1'b0;
  logic                 busy;
  logic [MODE_W-1:0]    in_mode    = MODE_RX;
  logic [BYTE_W-1:0]    in_rx_byte = '0;
  logic                 out_valid;
  logic [BYTE_W-1:0]    out_byte;
  logic                 out_last;
  logic                 out_empty_res;
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [BYTE_W-1:0]    cfg_data   = '0;

  // mirror of the block state, starting from its reset values
  logic [BYTE_W-1:0] start_mk = START_MARKER_RST;
  logic [BYTE_W-1:0] stop_mk  = STOP_MARKER_RST;
  logic [BYTE_W-1:0] frame_buf [FRAME_MAX];
  int unsigned       frame_len = 0;
  evt_t              bus_evt   = EVT_NONE;
  logic [BYTE_W-1:0] msg_mem [RING_DEPTH][FRAME_MAX];
  int unsigned       msg_len [RING_DEPTH];
  int unsigned       head_idx  = 0;
  int unsigned       tail_idx  = 0;
  bit                ring_full = 1'b0;
  bit                ready_flag = 1'b0;

  // results of the item just predicted, and all results still to come
  res_t step_res[$];
  res_t expected_res[$];

  // bookkeeping
  int err_count    = 0;
  int items_sent   = 0;
  int results_seen = 0;
  int n_kept       = 0;
  int n_refused    = 0;
  int n_discarded  = 0;
  int stall_cycles = 0;

  dir_row_t directed_rows [N_DIRECTED];

  framed_message_receive_queue_top uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_mode       (in_mode),
    .in_rx_byte    (in_rx_byte),
    .out_valid     (out_valid),
    .out_byte      (out_byte),
    .out_last      (out_last),
    .out_empty_res (out_empty_res),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // predictor: applies one accepted item to the mirrored state and leaves the
  // results it causes in step_res
  // ---------------------------------------------------------------------------
  function automatic void predict_item(input logic [MODE_W-1:0] mode,
                                       input logic [BYTE_W-1:0] data);
    res_t        r;
    int unsigned n;
    step_res.delete();
    case (mode)
      MODE_RX: begin
        // bytes past the frame limit fall on the floor, state untouched
        if (frame_len < FRAME_MAX) begin
          frame_buf[frame_len] = data;
          frame_len++;
          bus_evt = EVT_RX;
        end
      end
      MODE_READ: begin
        r = '0;
        r.byte_val[0] = ready_flag;
        r.fin = 1'b1;
        step_res.push_back(r);
        bus_evt = EVT_READ;
      end
      MODE_STOP: begin
        // commit only right after receiving, and only a well-framed message
        if (bus_evt == EVT_RX && frame_len > 0 && frame_buf[0] == start_mk &&
            frame_buf[frame_len-1] == stop_mk) begin
          if (ring_full) begin
            n_refused++;
          end else begin
            for (int i = 0; i < frame_len; i++) msg_mem[tail_idx][i] = frame_buf[i];
            msg_len[tail_idx] = frame_len;
            ready_flag = 1'b1;
            tail_idx = (tail_idx + 1) % RING_DEPTH;
            if (tail_idx == head_idx) ring_full = 1'b1;
            n_kept++;
          end
        end else if (frame_len > 0) begin
          n_discarded++;
        end
        // the assembly always empties, the last event stays as it was
        frame_len = 0;
      end
      default: begin
        if (head_idx == tail_idx && !ring_full) begin
          step_res.push_back(RES_EMPTY);
        end else begin
          n = msg_len[head_idx];
          for (int i = 0; i < n; i++) begin
            r.byte_val   = msg_mem[head_idx][i];
            r.fin        = (i + 1 == n);
            r.empty_flag = 1'b0;
            step_res.push_back(r);
          end
          head_idx   = (head_idx + 1) % RING_DEPTH;
          ring_full  = 1'b0;
          ready_flag = 1'b0;
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // sender: optional random gap, then hold start until the block takes the
  // item; start stays high afterwards so back-to-back items need no bubble
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic [MODE_W-1:0] mode, input logic [BYTE_W-1:0] data,
                           input int idle_pct, input bit typed, input res_t typed_res);
    int gap;
    gap = 0;
    while (idle_pct > 0 && gap < MAX_GAP && $urandom_range(0, 99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    in_mode    <= mode;
    in_rx_byte <= data;
    // busy read right after the edge is its value during the cycle just ended
    do @(posedge clk); while (busy);
    items_sent++;
    predict_item(mode, data);
    if (typed) begin
      expected_res.push_back(typed_res);
    end else begin
      foreach (step_res[i]) expected_res.push_back(step_res[i]);
    end
  endtask

  // random frame: body bytes, optional flaw, stop; sometimes overlong so the
  // stop marker lands on the last byte that still fits
  task automatic send_frame(input int idle_pct, input int max_short, input bit long_ok);
    logic [BYTE_W-1:0] body [$];
    logic [BYTE_W-1:0] flip;
    int                len;
    int                kept;
    int                flaw;
    if (long_ok && $urandom_range(0, 11) == 0) len = FRAME_MAX + $urandom_range(0, 3);
    else len = $urandom_range(1, max_short);
    kept = (len < FRAME_MAX) ? len : FRAME_MAX;
    flaw = $urandom_range(0, 9);
    flip = BYTE_W'($urandom_range(1, 255));
    for (int i = 0; i < len; i++) body.push_back(BYTE_W'($urandom_range(0, 255)));
    body[0]      = start_mk;
    body[kept-1] = stop_mk;
    // broken variants: wrong opening byte, wrong closing byte, read before stop
    if (flaw == 0) body[0] = body[0] ^ flip;
    if (flaw == 1) body[kept-1] = body[kept-1] ^ flip;
    foreach (body[i]) send_item(MODE_RX, body[i], idle_pct, 1'b0, NO_RES);
    if (flaw == 2)
      send_item(MODE_READ, BYTE_W'($urandom_range(0, 255)), idle_pct, 1'b0, NO_RES);
    send_item(MODE_STOP, BYTE_W'($urandom_range(0, 255)), idle_pct, 1'b0, NO_RES);
    if ($urandom_range(0, 7) == 0)
      send_item(MODE_STOP, BYTE_W'($urandom_range(0, 255)), idle_pct, 1'b0, NO_RES);
  endtask

  // one random phase; weights in percent, frames take what is left over; with
  // until_full it runs on for up to one more budget until a frame hit a full ring
  task automatic run_random(input int budget, input int idle_pct, input int pop_w,
                            input int read_w, input int noise_w, input int max_short,
                            input bit long_ok, input bit until_full);
    int stop_at;
    int pick;
    stop_at = items_sent + budget;
    while (items_sent < stop_at ||
           (until_full && n_refused == 0 && items_sent < stop_at + budget)) begin
      pick = $urandom_range(0, 99);
      if (pick < pop_w)
        send_item(MODE_POP, BYTE_W'($urandom_range(0, 255)), idle_pct, 1'b0, NO_RES);
      else if (pick < pop_w + read_w)
        send_item(MODE_READ, BYTE_W'($urandom_range(0, 255)), idle_pct, 1'b0, NO_RES);
      else if (pick < pop_w + read_w + noise_w)
        send_item(MODE_W'($urandom_range(0, 3)), BYTE_W'($urandom_range(0, 255)),
                  idle_pct, 1'b0, NO_RES);
      else
        send_frame(idle_pct, max_short, long_ok);
    end
  endtask

  // stop sending, let every expected result arrive, then give a silent
  // commit time to finish its copy before anything else happens
  task automatic drain_and_settle();
    start <= 1'b0;
    while (expected_res.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_START_MARKER) start_mk = val;
    else if (idx == CFG_STOP_MARKER) stop_mk = val;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    err_count++;
  endtask

  // ---------------------------------------------------------------------------
  // result checker: the receiver never stalls, so every strobe is an item
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_res
    res_t want;
    if (rst_n && out_valid) begin
      results_seen++;
      if (expected_res.size() == 0) begin
        report_mismatch($sformatf("unexpected result byte=%02h last=%0b empty=%0b",
                                  out_byte, out_last, out_empty_res));
      end else begin
        want = expected_res.pop_front();
        if (out_byte !== want.byte_val)
          report_mismatch($sformatf("result %0d byte got %02h want %02h",
                                    results_seen, out_byte, want.byte_val));
        if (out_last !== want.fin)
          report_mismatch($sformatf("result %0d last got %0b want %0b",
                                    results_seen, out_last, want.fin));
        if (out_empty_res !== want.empty_flag)
          report_mismatch($sformatf("result %0d empty got %0b want %0b",
                                    results_seen, out_empty_res, want.empty_flag));
      end
    end
  end

  // watchdog: any handshake on any channel counts as progress
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    logic [BYTE_W-1:0] mk;
    int                n_directed;

    // directed table, default markers FA / FB
    directed_rows = '{
      '{MODE_READ, 8'hFF, 1'b1, RES_FLAG_LO},  // flag low out of reset
      '{MODE_POP,  8'h00, 1'b1, RES_EMPTY},    // pop on an empty ring
      '{MODE_STOP, 8'hFF, 1'b0, NO_RES},       // stop with nothing received
      '{MODE_RX,   8'hFA, 1'b0, NO_RES},
      '{MODE_RX,   8'h00, 1'b0, NO_RES},
      '{MODE_RX,   8'hFF, 1'b0, NO_RES},
      '{MODE_RX,   8'hFB, 1'b0, NO_RES},
      '{MODE_STOP, 8'h00, 1'b0, NO_RES},       // good frame, kept
      '{MODE_STOP, 8'hFF, 1'b0, NO_RES},       // repeated stop keeps nothing
      '{MODE_READ, 8'h00, 1'b1, RES_FLAG_HI},
      '{MODE_RX,   8'hFA, 1'b0, NO_RES},
      '{MODE_RX,   8'hFB, 1'b0, NO_RES},
      '{MODE_READ, 8'h55, 1'b1, RES_FLAG_HI},  // read between frame and stop
      '{MODE_STOP, 8'hAA, 1'b0, NO_RES},       // so this frame is dropped
      '{MODE_RX,   8'h55, 1'b0, NO_RES},
      '{MODE_RX,   8'hFB, 1'b0, NO_RES},
      '{MODE_STOP, 8'h00, 1'b0, NO_RES},       // wrong opening byte
      '{MODE_RX,   8'hFA, 1'b0, NO_RES},
      '{MODE_RX,   8'h7E, 1'b0, NO_RES},
      '{MODE_STOP, 8'h00, 1'b0, NO_RES},       // wrong closing byte
      '{MODE_POP,  8'hFF, 1'b0, NO_RES},       // the one kept frame, via predictor
      '{MODE_POP,  8'h00, 1'b1, RES_EMPTY},
      '{MODE_READ, 8'h00, 1'b1, RES_FLAG_LO}   // pop cleared the flag
    };

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_item(directed_rows[i].mode, directed_rows[i].data, 0,
                directed_rows[i].typed, directed_rows[i].want);
    n_directed = items_sent;

    // extreme markers, back-to-back items, some overlong frames
    drain_and_settle();
    write_cfg_reg(CFG_START_MARKER, 8'h00);
    write_cfg_reg(CFG_STOP_MARKER, 8'hFF);
    run_random(20, 0, 20, 10, 10, 6, 1'b1, 1'b0);

    // markers the other way round, sender mostly idle
    drain_and_settle();
    write_cfg_reg(CFG_START_MARKER, 8'hFF);
    write_cfg_reg(CFG_STOP_MARKER, 8'h00);
    run_random(15, 73, 20, 10, 10, 6, 1'b1, 1'b0);

    // equal markers allow one-byte frames; almost no pops so the ring fills
    // and frames get refused; a write to an unused index must change nothing
    drain_and_settle();
    mk = BYTE_W'($urandom_range(0, 255));
    write_cfg_reg(CFG_IDX_UNUSED, ~mk);
    write_cfg_reg(CFG_START_MARKER, mk);
    write_cfg_reg(CFG_STOP_MARKER, mk);
    run_random(50, 28, 0, 5, 5, 1, 1'b0, 1'b1);

    // random markers, pop heavy to drain the ring
    drain_and_settle();
    write_cfg_reg(CFG_START_MARKER, BYTE_W'($urandom_range(0, 255)));
    write_cfg_reg(CFG_STOP_MARKER, BYTE_W'($urandom_range(0, 255)));
    run_random(20, 0, 40, 10, 10, 6, 1'b1, 1'b0);

    drain_and_settle();

    $display("covered %0d items (%0d directed) under four marker settings, %0d results checked",
             items_sent, n_directed, results_seen);
    $display("frames: %0d queued, %0d refused on a full ring, %0d thrown away",
             n_kept, n_refused, n_discarded);
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", err_count);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
